### rtl/rusi_pkg.sv
// shared constants of the unit-sphere ray intersection block
// depends on nothing; used by the interfaces, the root pipeline and the top level
package rusi_pkg;

	// widths of the fixed word fields
	localparam int COORD_W = 32;
	localparam int DIST_W = 31;

	// default number of fraction bits of the fixed-point format
	localparam int FRAC_BITS_DEF = 16;

	// direction magnitudes are scaled so the largest lies in [2^(NORM_W-1), 2^NORM_W)
	localparam int NORM_W = 30;

	// integer square root: radicand and root widths
	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;

endpackage

### rtl/rusi_if.sv
// valid/ready channels of the unit-sphere ray intersection block
// depends on rusi_pkg for field widths
interface rusi_ray_if;
	logic valid;
	logic ready;
	logic signed [rusi_pkg::COORD_W-1:0] origin_x;
	logic signed [rusi_pkg::COORD_W-1:0] origin_y;
	logic signed [rusi_pkg::COORD_W-1:0] origin_z;
	logic signed [rusi_pkg::COORD_W-1:0] dir_x;
	logic signed [rusi_pkg::COORD_W-1:0] dir_y;
	logic signed [rusi_pkg::COORD_W-1:0] dir_z;

	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rusi_hit_if;
	logic valid;
	logic ready;
	logic hit;
	logic [rusi_pkg::DIST_W-1:0] distance;
	logic signed [rusi_pkg::COORD_W-1:0] point_x;
	logic signed [rusi_pkg::COORD_W-1:0] point_y;
	logic signed [rusi_pkg::COORD_W-1:0] point_z;

	modport source(output valid, hit, distance, point_x, point_y, point_z, input ready);
	modport sink(input valid, hit, distance, point_x, point_y, point_z, output ready);
endinterface

### rtl/ray_unit_sphere_intersect_top.sv
// unit-sphere ray intersection: normalise, dot, discriminant, root, hit point
// depends on rusi_pkg, rusi_ray_if / rusi_hit_if and rusi_sqrt_pipe
//
//  channel  dir  handshake      word
//  ray      in   valid/ready    origin_x/y/z, dir_x/y/z (signed fixed point)
//  isect    out  valid/ready    hit, distance, point_x/y/z
//
// one ray a cycle while the skid word is empty; the pipeline holds the two
// bit-per-stage square root pipelines and the bit-per-stage length division
// the whole pipeline advances together; an output register plus a skid word
// let the pipeline run on while a result waits, ready comes from a flop
// reset clears the valid bits only
module ray_unit_sphere_intersect_top #(
	parameter int FRAC_BITS = rusi_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rusi_ray_if.sink  ray,
	rusi_hit_if.source isect
);
	localparam int CW = rusi_pkg::COORD_W;
	localparam int DSW = rusi_pkg::DIST_W;
	localparam int NW = rusi_pkg::NORM_W;
	localparam int RW = rusi_pkg::RAD_W;
	localparam int LW = rusi_pkg::ROOT_W;
	localparam int SHW = $clog2(CW);
	localparam int QW = FRAC_BITS + 1;
	localparam int UW = FRAC_BITS + 2;
	localparam int NUMW = NW + QW + 1;
	localparam int PRW = CW + UW;
	localparam int DW = PRW + 2;
	localparam int PW = 34;
	localparam int SQW = 2 * CW;
	localparam int HW = SQW + 2;
	localparam int TW = 36;
	localparam int MW = QW + TW - 1;
	localparam int QOW = MW + 1 - FRAC_BITS;
	localparam int OW = QOW + 1;
	localparam int SW = (OW > CW ? OW : CW) + 1;

	localparam logic [DW-1:0] HALF_D = DW'(1) << (FRAC_BITS - 1);
	localparam logic [MW:0] HALF_M = (MW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [HW-1:0] ONE_SQ = HW'(1) << (2 * FRAC_BITS);

	// ray data that rides along most of the pipeline
	typedef struct packed {
		logic [2:0][CW-1:0] o;
		logic [2:0]         dneg;
		logic               zero;
	} ride_t;

	typedef struct packed {
		ride_t              rd;
		logic [2:0][NW-1:0] an;
	} nrm_t;

	typedef struct packed {
		logic [2:0][LW-1:0] rem;
		logic [2:0][QW-1:0] low;
		logic [2:0][QW-1:0] q;
		logic [LW-1:0]      len;
		ride_t              rd;
	} dv_t;

	typedef struct packed {
		logic [2:0][CW-1:0] o;
		logic [2:0][QW-1:0] um;
		logic [2:0]         dneg;
		logic signed [TW-1:0] np;
		logic               miss;
	} hsd_t;

	typedef struct packed {
		logic                hit;
		logic [DSW-1:0]      distance;
		logic [2:0][CW-1:0]  pt;
	} res_t;

	logic en;
	logic skid_vld_q;
	logic out_vld_q;
	res_t out_q;
	res_t skid_q;

	assign en = !skid_vld_q;
	assign ray.ready = en;

	// ---------------- s1: take the ray, direction magnitudes
	logic vld_s1;
	ride_t rd_s1;
	logic [2:0][CW-1:0] mag_s1;
	logic [2:0][CW-1:0] din;

	assign din = {ray.dir_z, ray.dir_y, ray.dir_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ray.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s1.o <= {ray.origin_z, ray.origin_y, ray.origin_x};
			for (int l = 0; l < 3; l++) begin
				rd_s1.dneg[l] <= din[l][CW-1];
				mag_s1[l] <= din[l][CW-1] ? CW'(-din[l]) : din[l];
			end
			rd_s1.zero <= 1'b0;
		end
	end

	// ---------------- s2: scale the magnitudes so the largest has its top bit fixed
	logic vld_s2;
	nrm_t nm_s2;
	logic [CW-1:0] orv;
	logic [SHW-1:0] msb;
	logic [2:0][CW-1:0] shd;

	always_comb begin
		orv = mag_s1[0] | mag_s1[1] | mag_s1[2];
		msb = '0;
		for (int i = 0; i < CW; i++) begin
			if (orv[i]) begin
				msb = SHW'(i);
			end
		end
		for (int l = 0; l < 3; l++) begin
			if (msb >= SHW'(NW)) begin
				shd[l] = mag_s1[l] >> (msb - SHW'(NW - 1));
			end else begin
				shd[l] = mag_s1[l] << (SHW'(NW - 1) - msb);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s2.rd.o <= rd_s1.o;
			nm_s2.rd.dneg <= rd_s1.dneg;
			nm_s2.rd.zero <= (orv == '0);
			for (int l = 0; l < 3; l++) begin
				nm_s2.an[l] <= shd[l][NW-1:0];
			end
		end
	end

	// ---------------- s3: squares of the scaled magnitudes
	logic vld_s3;
	nrm_t nm_s3;
	logic [2:0][2*NW-1:0] sq_s3;
	logic [2:0][2*NW-1:0] sq_c;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sq_c[l] = nm_s2.an[l] * nm_s2.an[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s3 <= nm_s2;
			sq_s3 <= sq_c;
		end
	end

	// ---------------- s4: four times the squared length
	logic vld_s4;
	nrm_t nm_s4;
	logic [RW-1:0] rad_s4;
	logic [2*NW+1:0] sqsum;

	assign sqsum = (2*NW+2)'(sq_s3[0]) + (2*NW+2)'(sq_s3[1]) + (2*NW+2)'(sq_s3[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s4 <= nm_s3;
			rad_s4 <= RW'({sqsum, 2'b00});
		end
	end

	// ---------------- length root
	logic len_vld;
	logic [LW-1:0] len_root;
	logic [$bits(nrm_t)-1:0] len_side;
	nrm_t nm_len;

	rusi_sqrt_pipe #(
		.SIDE_W($bits(nrm_t))
	) u_len_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s4),
		.in_rad(rad_s4),
		.in_side(nm_s4),
		.out_valid(len_vld),
		.out_root(len_root),
		.out_side(len_side)
	);

	assign nm_len = nrm_t'(len_side);

	// ---------------- division of each magnitude by the length, one quotient bit a stage
	logic vld_dv [QW+1];
	dv_t dv_s [QW+1];
	logic [2:0][NUMW-1:0] num;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num[l] = NUMW'({nm_len.an[l], QW'(0)}) + NUMW'(len_root >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv[0] <= 1'b0;
		end else if (en) begin
			vld_dv[0] <= len_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				dv_s[0].rem[l] <= LW'(num[l][NUMW-1:QW]);
				dv_s[0].low[l] <= num[l][QW-1:0];
				dv_s[0].q[l] <= '0;
			end
			dv_s[0].len <= len_root;
			dv_s[0].rd <= nm_len.rd;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_div
		dv_t nx;
		logic [LW:0] tr;

		always_comb begin
			nx = dv_s[k-1];
			tr = '0;
			for (int l = 0; l < 3; l++) begin
				tr = {dv_s[k-1].rem[l], dv_s[k-1].low[l][QW-1]};
				nx.low[l] = dv_s[k-1].low[l] << 1;
				if (tr >= {1'b0, dv_s[k-1].len}) begin
					nx.rem[l] = LW'(tr - {1'b0, dv_s[k-1].len});
					nx.q[l] = {dv_s[k-1].q[l][QW-2:0], 1'b1};
				end else begin
					nx.rem[l] = tr[LW-1:0];
					nx.q[l] = {dv_s[k-1].q[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[k] <= 1'b0;
			end else if (en) begin
				vld_dv[k] <= vld_dv[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= nx;
			end
		end
	end

	// ---------------- s6: signed unit direction
	logic vld_s6;
	ride_t rd_s6;
	logic [2:0][QW-1:0] um_s6;
	logic signed [UW-1:0] us_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_dv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s6 <= dv_s[QW].rd;
			um_s6 <= dv_s[QW].q;
			for (int l = 0; l < 3; l++) begin
				us_s6[l] <= dv_s[QW].rd.dneg[l] ? -$signed(UW'(dv_s[QW].q[l]))
					: $signed(UW'(dv_s[QW].q[l]));
			end
		end
	end

	// ---------------- s7: origin times direction, origin squared
	logic vld_s7;
	ride_t rd_s7;
	logic [2:0][QW-1:0] um_s7;
	logic signed [PRW-1:0] prd_s7 [3];
	logic [SQW-1:0] osq_s7 [3];
	logic signed [PRW-1:0] prd_c [3];
	logic signed [SQW-1:0] osq_c [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			prd_c[l] = $signed(rd_s6.o[l]) * us_s6[l];
			osq_c[l] = $signed(rd_s6.o[l]) * $signed(rd_s6.o[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s7 <= rd_s6;
			um_s7 <= um_s6;
			for (int l = 0; l < 3; l++) begin
				prd_s7[l] <= prd_c[l];
				osq_s7[l] <= osq_c[l];
			end
		end
	end

	// ---------------- s8: dot product and squared origin length
	logic vld_s8;
	ride_t rd_s8;
	logic [2:0][QW-1:0] um_s8;
	logic signed [DW-1:0] dot_s8;
	logic [SQW-1:0] oo_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s8 <= rd_s7;
			um_s8 <= um_s7;
			dot_s8 <= DW'(prd_s7[0]) + DW'(prd_s7[1]) + DW'(prd_s7[2]);
			oo_s8 <= osq_s7[0] + osq_s7[1] + osq_s7[2];
		end
	end

	// ---------------- s9: magnitude of the dot product
	logic vld_s9;
	ride_t rd_s9;
	logic [2:0][QW-1:0] um_s9;
	logic [DW-1:0] dmag_s9;
	logic pneg_s9;
	logic [SQW-1:0] oo_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s9 <= rd_s8;
			um_s9 <= um_s8;
			dmag_s9 <= dot_s8[DW-1] ? DW'(-dot_s8) : DW'(dot_s8);
			pneg_s9 <= dot_s8[DW-1];
			oo_s9 <= oo_s8;
		end
	end

	// ---------------- s10: round the projection to the fixed-point format
	logic vld_s10;
	ride_t rd_s10;
	logic [2:0][QW-1:0] um_s10;
	logic [PW-1:0] pm_s10;
	logic pneg_s10;
	logic [SQW-1:0] oo_s10;
	logic [DW-1:0] dround;

	assign dround = (dmag_s9 + HALF_D) >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s10 <= rd_s9;
			um_s10 <= um_s9;
			pm_s10 <= dround[PW-1:0];
			pneg_s10 <= pneg_s9;
			oo_s10 <= oo_s9;
		end
	end

	// ---------------- s11: projection squared, negated projection
	logic vld_s11;
	ride_t rd_s11;
	logic [2:0][QW-1:0] um_s11;
	logic [SQW-1:0] p2_s11;
	logic signed [TW-1:0] np_s11;
	logic [SQW-1:0] oo_s11;
	logic [2*PW-1:0] p2_c;

	assign p2_c = pm_s10 * pm_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s11 <= rd_s10;
			um_s11 <= um_s10;
			p2_s11 <= p2_c[SQW-1:0];
			np_s11 <= pneg_s10 ? $signed(TW'(pm_s10)) : -$signed(TW'(pm_s10));
			oo_s11 <= oo_s10;
		end
	end

	// ---------------- s12: projection squared less origin length squared
	logic vld_s12;
	ride_t rd_s12;
	logic [2:0][QW-1:0] um_s12;
	logic signed [TW-1:0] np_s12;
	logic signed [HW-1:0] diff_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s12 <= rd_s11;
			um_s12 <= um_s11;
			np_s12 <= np_s11;
			diff_s12 <= $signed({2'b00, p2_s11}) - $signed({2'b00, oo_s11});
		end
	end

	// ---------------- s13: discriminant; zero direction, tangent or no crossing is a miss
	logic vld_s13;
	hsd_t hs_s13;
	logic [RW-1:0] h_s13;
	logic signed [HW-1:0] hf;

	assign hf = diff_s12 + ONE_SQ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s13.o <= rd_s12.o;
			hs_s13.um <= um_s12;
			hs_s13.dneg <= rd_s12.dneg;
			hs_s13.np <= np_s12;
			hs_s13.miss <= rd_s12.zero || hf[HW-1] || (hf == '0);
			h_s13 <= hf[RW-1:0];
		end
	end

	// ---------------- discriminant root
	logic s_vld;
	logic [LW-1:0] s_root;
	logic [$bits(hsd_t)-1:0] s_side;
	hsd_t hs_sq;

	rusi_sqrt_pipe #(
		.SIDE_W($bits(hsd_t))
	) u_disc_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s13),
		.in_rad(h_s13),
		.in_side(hs_s13),
		.out_valid(s_vld),
		.out_root(s_root),
		.out_side(s_side)
	);

	assign hs_sq = hsd_t'(s_side);

	// ---------------- s14: both roots
	logic vld_s14;
	hsd_t hs_s14;
	logic signed [TW-1:0] t1_s14;
	logic signed [TW-1:0] t2_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s14 <= s_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s14 <= hs_sq;
			t1_s14 <= hs_sq.np - $signed(TW'(s_root));
			t2_s14 <= hs_sq.np + $signed(TW'(s_root));
		end
	end

	// ---------------- s15: nearest positive root and saturated distance
	logic vld_s15;
	hsd_t hs_s15;
	logic [TW-2:0] t_s15;
	logic [DSW-1:0] dist_s15;
	logic t1_pos;
	logic t2_pos;
	logic [TW-2:0] t_sel;

	always_comb begin
		t1_pos = !t1_s14[TW-1] && (t1_s14 != '0);
		t2_pos = !t2_s14[TW-1] && (t2_s14 != '0);
		t_sel = t1_pos ? t1_s14[TW-2:0] : t2_s14[TW-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s15 <= 1'b0;
		end else if (en) begin
			vld_s15 <= vld_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s15.o <= hs_s14.o;
			hs_s15.um <= hs_s14.um;
			hs_s15.dneg <= hs_s14.dneg;
			hs_s15.np <= hs_s14.np;
			hs_s15.miss <= hs_s14.miss || !(t1_pos || t2_pos);
			t_s15 <= t_sel;
			dist_s15 <= (|t_sel[TW-2:DSW]) ? {DSW{1'b1}} : t_sel[DSW-1:0];
		end
	end

	// ---------------- s16: direction times distance
	logic vld_s16;
	hsd_t hs_s16;
	logic [DSW-1:0] dist_s16;
	logic [2:0][MW-1:0] mp_s16;
	logic [2:0][MW-1:0] mp_c;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			mp_c[l] = hs_s15.um[l] * t_s15;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
		end else if (en) begin
			vld_s16 <= vld_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s16 <= hs_s15;
			dist_s16 <= dist_s15;
			mp_s16 <= mp_c;
		end
	end

	// ---------------- s17: rounded signed offset along each axis
	logic vld_s17;
	hsd_t hs_s17;
	logic [DSW-1:0] dist_s17;
	logic signed [OW-1:0] off_s17 [3];
	logic [MW:0] qsh [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qsh[l] = ({1'b0, mp_s16[l]} + HALF_M) >> FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s17 <= 1'b0;
		end else if (en) begin
			vld_s17 <= vld_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s17 <= hs_s16;
			dist_s17 <= dist_s16;
			for (int l = 0; l < 3; l++) begin
				off_s17[l] <= hs_s16.dneg[l] ? -$signed({1'b0, qsh[l][QOW-1:0]})
					: $signed({1'b0, qsh[l][QOW-1:0]});
			end
		end
	end

	// ---------------- s18: hit point with saturation, misses give all zeros
	logic vld_s18;
	res_t res_s18;
	logic signed [SW-1:0] pt [3];
	res_t res_c;

	always_comb begin
		res_c.hit = !hs_s17.miss;
		res_c.distance = hs_s17.miss ? '0 : dist_s17;
		for (int l = 0; l < 3; l++) begin
			pt[l] = SW'($signed(hs_s17.o[l])) + SW'(off_s17[l]);
			if (hs_s17.miss) begin
				res_c.pt[l] = '0;
			end else if ((&pt[l][SW-1:CW-1]) || !(|pt[l][SW-1:CW-1])) begin
				res_c.pt[l] = pt[l][CW-1:0];
			end else if (pt[l][SW-1]) begin
				res_c.pt[l] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				res_c.pt[l] = {1'b0, {(CW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
		end else if (en) begin
			vld_s18 <= vld_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s18 <= res_c;
		end
	end

	// ---------------- output register and skid word
	logic push;

	assign push = en && vld_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || isect.ready) begin
			out_vld_q <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || isect.ready) begin
			out_q <= skid_vld_q ? skid_q : res_s18;
		end else if (push) begin
			skid_q <= res_s18;
		end
	end

	assign isect.valid = out_vld_q;
	assign isect.hit = out_q.hit;
	assign isect.distance = out_q.distance;
	assign isect.point_x = out_q.pt[0];
	assign isect.point_y = out_q.pt[1];
	assign isect.point_z = out_q.pt[2];

	// ---------------- checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held without a waiting output word");

	a_hit_has_distance: assert property (@(posedge clk) disable iff (!arst_n)
		(isect.valid && isect.hit) |-> (isect.distance != '0))
		else $error("hit with zero distance");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(isect.valid && !isect.hit) |-> (isect.distance == '0 && isect.point_x == '0
			&& isect.point_y == '0 && isect.point_z == '0))
		else $error("miss word carries nonzero fields");

	a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !isect.ready) |=> (skid_vld_q && $stable(skid_q)))
		else $error("skid word lost during a stall");

endmodule

### rtl/rusi_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage, with side data alongside
// depends on rusi_pkg for radicand and root widths
module rusi_sqrt_pipe #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [rusi_pkg::RAD_W-1:0]   in_rad,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic [rusi_pkg::ROOT_W-1:0]  out_root,
	output logic [SIDE_W-1:0]            out_side
);
	localparam int RAD_W = rusi_pkg::RAD_W;
	localparam int ROOT_W = rusi_pkg::ROOT_W;
	localparam int STEPS = ROOT_W;
	localparam int REM_W = ROOT_W + 4;

	logic              vld_s  [STEPS];
	logic [RAD_W-1:0]  rad_s  [STEPS];
	logic [REM_W-1:0]  rem_s  [STEPS];
	logic [ROOT_W-1:0] root_s [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic              cur_vld;
		logic [RAD_W-1:0]  cur_rad;
		logic [REM_W-1:0]  cur_rem;
		logic [ROOT_W-1:0] cur_root;
		logic [SIDE_W-1:0] cur_side;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_rad = in_rad;
			assign cur_rem = '0;
			assign cur_root = '0;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_vld = vld_s[k-1];
			assign cur_rad = rad_s[k-1];
			assign cur_rem = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_side = side_s[k-1];
		end

		// bring down the next two radicand bits and try the next root bit
		always_comb begin
			rem_sh = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1 -: 2]};
			trial = {2'b00, cur_root, 2'b01};
			ge = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= cur_rad << 2;
				rem_s[k] <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {cur_root[ROOT_W-2:0], ge};
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_root = root_s[STEPS-1];
	assign out_side = side_s[STEPS-1];

endmodule

### verif/tb_ray_unit_sphere_intersect_top.sv
// testbench for ray_unit_sphere_intersect_top: directed table then random rays,
// every result word checked against a hand-typed result or an in-bench fixed-point intersection model
// depends on rusi_pkg and the rusi_ray_if / rusi_hit_if interfaces
module tb_ray_unit_sphere_intersect_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = rusi_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = 2 * 32 + FB + 19;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM = 1400;
	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FB;

	typedef struct packed {
		logic signed [31:0] ox, oy, oz, dx, dy, dz;
	} ray_t;

	typedef struct packed {
		logic hit;
		logic [rusi_pkg::DIST_W-1:0] distance;
		logic signed [31:0] px, py, pz;
	} isect_t;

	// directed row: known marks a result typed in by hand
	typedef struct packed {
		ray_t r;
		logic known;
		isect_t res;
	} row_t;

	logic clk;
	logic arst_n;
	rusi_ray_if ray ();
	rusi_hit_if isect ();

	ray_unit_sphere_intersect_top #(.FRAC_BITS(FB)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.ray(ray.sink),
		.isect(isect.source)
	);

	isect_t pending_hits[$];
	int n_errors = 0;
	bit idle_off = 0;
	longint cycles = 0;

	// clock, reset and cycle limit
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_ray_unit_sphere_intersect_top: done, errors");
			$finish;
		end
	end

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] magn(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	// fixed-point normalise, half-form quadratic, nearer positive root, hit point
	function automatic isect_t sphere_hit(input ray_t r);
		isect_t res;
		longint o[3], d[3], u[3];
		logic [63:0] a[3], mx, sq, len, m, pm, p2, oo, one, h, s, prod, q;
		longint dot, p, t1, t2, t, pt;
		res = '0;
		o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
		d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = magn(d[i]);
			if (a[i] > mx) mx = a[i];
		end
		// zero direction is a miss
		if (mx == 0) return res;
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
			mx = mx >> 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
			mx = mx << 1;
		end
		sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		len = isqrt(sq << 2);
		for (int i = 0; i < 3; i++) begin
			m = ((a[i] << (FB + 1)) + (len >> 1)) / len;
			u[i] = d[i] < 0 ? -longint'(m) : longint'(m);
		end
		dot = o[0] * u[0] + o[1] * u[1] + o[2] * u[2];
		pm = (magn(dot) + (64'd1 << (FB - 1))) >> FB;
		p = dot < 0 ? -longint'(pm) : longint'(pm);
		p2 = pm * pm;
		oo = magn(o[0]) * magn(o[0]) + magn(o[1]) * magn(o[1]) + magn(o[2]) * magn(o[2]);
		one = 64'd1 << (2 * FB);
		// tangent or no crossing is a miss
		if (p2 >= oo) h = p2 - oo + one;
		else if (oo - p2 >= one) return res;
		else h = one - (oo - p2);
		s = isqrt(h);
		t1 = -p - longint'(s);
		t2 = -p + longint'(s);
		if (t1 > 0) t = t1;
		else if (t2 > 0) t = t2;
		else return res; // sphere behind the origin
		res.hit = 1;
		res.distance = t > 64'sd2147483647 ? 31'h7fffffff : t[rusi_pkg::DIST_W-1:0];
		for (int i = 0; i < 3; i++) begin
			prod = magn(u[i]) * 64'(t);
			q = (prod + (64'd1 << (FB - 1))) >> FB;
			pt = o[i] + (u[i] < 0 ? -longint'(q) : longint'(q));
			if (pt > 64'sd2147483647) pt = 64'sd2147483647;
			if (pt < -64'sd2147483648) pt = -64'sd2147483648;
			if (i == 0) res.px = pt[31:0];
			else if (i == 1) res.py = pt[31:0];
			else res.pz = pt[31:0];
		end
		return res;
	endfunction

	// result side: check each accepted word, ready idles at random
	initial begin
		isect.ready <= 0;
		forever begin
			isect_t got, want;
			@(posedge clk);
			if (arst_n && isect.valid && isect.ready) begin
				got = '{isect.hit, isect.distance, isect.point_x, isect.point_y,
					isect.point_z};
				if (pending_hits.size() == 0) begin
					$error("result word with nothing expected");
					n_errors++;
				end else begin
					want = pending_hits.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit exp %0d got %0d", want.hit, got.hit); n_errors++;
					end
					if (got.distance !== want.distance) begin
						$error("distance exp %0d got %0d", want.distance, got.distance);
						n_errors++;
					end
					if (got.px !== want.px) begin
						$error("point_x exp %0d got %0d", want.px, got.px); n_errors++;
					end
					if (got.py !== want.py) begin
						$error("point_y exp %0d got %0d", want.py, got.py); n_errors++;
					end
					if (got.pz !== want.pz) begin
						$error("point_z exp %0d got %0d", want.pz, got.pz); n_errors++;
					end
				end
			end
			isect.ready <= idle_off || ($urandom_range(99) >= 20);
		end
	end

	// offer one ray word, with a random gap first, and wait for acceptance
	task automatic send_ray(input ray_t r, input isect_t want);
		if (!idle_off && $urandom_range(99) < 10) begin
			ray.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		ray.valid <= 1;
		ray.origin_x <= r.ox; ray.origin_y <= r.oy; ray.origin_z <= r.oz;
		ray.dir_x <= r.dx; ray.dir_y <= r.dy; ray.dir_z <= r.dz;
		do @(posedge clk); while (!ray.ready);
		pending_hits.push_back(want);
	endtask

	function automatic logic signed [31:0] rnd_q(input int lim);
		return $signed($urandom_range(2 * lim)) - lim;
	endfunction

	// random ray: mostly aimed near the sphere, the rest from near the centre with tiny directions, raw or extreme
	function automatic ray_t rnd_ray();
		ray_t r;
		int kind;
		kind = $urandom_range(99);
		if (kind < 60) begin
			r.ox = rnd_q(8 * ONE_Q); r.oy = rnd_q(8 * ONE_Q); r.oz = rnd_q(8 * ONE_Q);
			r.dx = rnd_q(ONE_Q) - r.ox; r.dy = rnd_q(ONE_Q) - r.oy;
			r.dz = rnd_q(ONE_Q) - r.oz;
			if ($urandom_range(3) == 0) begin
				r.dx = r.dx >>> $urandom_range(15); r.dy = r.dy >>> $urandom_range(15);
				r.dz = r.dz >>> $urandom_range(15);
			end
		end else if (kind < 75) begin
			r.ox = rnd_q(ONE_Q); r.oy = rnd_q(ONE_Q); r.oz = rnd_q(ONE_Q);
			r.dx = rnd_q(4); r.dy = rnd_q(4); r.dz = rnd_q(4);
		end else if (kind < 90) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			r.ox = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			r.oy = $urandom_range(1) ? -r.ox : rnd_q(ONE_Q);
			r.oz = $urandom_range(1) ? r.ox : 0;
			r.dx = -r.ox; r.dy = -r.oy; r.dz = $urandom;
		end
		return r;
	endfunction

	localparam isect_t MISS = '0;
	localparam row_t DIRECTED[12] = '{
		// zero direction
		'{'{ONE_Q, 0, 0, 0, 0, 0}, 1'b1, MISS},
		// straight through from outside
		'{'{0, 0, -5 * ONE_Q, 0, 0, ONE_Q}, 1'b1, '{1'b1, 31'(4 * ONE_Q), 0, 0, -ONE_Q}},
		// from the centre, only the far root is positive
		'{'{0, 0, 0, 3 * ONE_Q, 0, 0}, 1'b1, '{1'b1, 31'(ONE_Q), ONE_Q, 0, 0}},
		// sphere behind the origin
		'{'{0, 0, 5 * ONE_Q, 0, 0, ONE_Q}, 1'b1, MISS},
		// tangent ray
		'{'{ONE_Q, 0, -5 * ONE_Q, 0, 0, ONE_Q}, 1'b1, MISS},
		// passing wide of the sphere
		'{'{2 * ONE_Q, 0, -5 * ONE_Q, 0, 0, 7}, 1'b1, MISS},
		// extremes, left to the model
		'{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff}, 1'b0, MISS},
		'{'{32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0}, 1'b0, MISS},
		'{'{32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0}, 1'b0, MISS},
		'{'{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, MISS},
		'{'{0, 0, 0, 32'sd1, -32'sd1, 32'sd1}, 1'b0, MISS},
		'{'{-1, -1, -1, 32'hffff_ffff, 0, 32'h7fff_ffff}, 1'b0, MISS}
	};

	// stimulus: directed table, drain, random rays with a stretch of no idling
	initial begin
		ray.valid <= 0;
		ray.origin_x <= 0; ray.origin_y <= 0; ray.origin_z <= 0;
		ray.dir_x <= 0; ray.dir_y <= 0; ray.dir_z <= 0;
		@(posedge arst_n);
		@(posedge clk);
		foreach (DIRECTED[k])
			send_ray(DIRECTED[k].r,
				DIRECTED[k].known ? DIRECTED[k].res : sphere_hit(DIRECTED[k].r));
		ray.valid <= 0;
		while (pending_hits.size() != 0) @(posedge clk);
		for (int n = 0; n < N_RANDOM; n++) begin
			ray_t r;
			idle_off = (n >= 500 && n < 800);
			r = rnd_ray();
			send_ray(r, sphere_hit(r));
		end
		ray.valid <= 0;
		idle_off = 0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (n_errors == 0)
			$display("tb_ray_unit_sphere_intersect_top: done, clean");
		else
			$display("tb_ray_unit_sphere_intersect_top: done, errors");
		$finish;
	end
endmodule

### files.f
rtl/rusi_pkg.sv
rtl/rusi_if.sv
rtl/rusi_sqrt_pipe.sv
rtl/ray_unit_sphere_intersect_top.sv
verif/tb_ray_unit_sphere_intersect_top.sv
